/* src/rsfe_pkg.sv */
`default_nettype none
package rsfe_pkg;

    localparam logic [1:0] OP_RX_BYTE   = 2'd0;
    localparam logic [1:0] OP_FRAME_END = 2'd1;
    localparam logic [1:0] OP_TX_DONE   = 2'd2;
    localparam logic [1:0] OP_UNUSED    = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_CHECK     = 2'd1;
    localparam logic [1:0] ST_FUNCTION  = 2'd2;
    localparam logic [1:0] ST_COUNT     = 2'd3;

    localparam logic [7:0] FN_READ      = 8'h03;
    localparam logic [7:0] FN_WRITE     = 8'h10;

    // register count after the limit check (limit is at most 125)
    localparam int CNT_W       = 7;
    localparam int RESP_DEPTH  = 256;
    localparam int RESP_AW     = 8;
    localparam int MIN_FRAME   = 8;
    localparam int WRITE_LEN   = 8;

    typedef struct packed {
        logic clr;
        logic rx_store;
        logic check;
        logic mod_step;
        logic rd_tab;
        logic rd_hi;
        logic rd_lo;
        logic wr_a;
        logic wr_b;
        logic wr_c;
        logic seal;
        logic tx_adv;
        logic tx_rd;
        logic tx_form;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic chk_rej;
        logic is_read;
        logic cnt_zero;
        logic mod_last;
        logic loop_last;
        logic tx_has;
        logic out_free;
    } sts_t;

endpackage
`default_nettype wire

/* src/rsfe_ctrl.sv */
`default_nettype none
module rsfe_ctrl (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               in_valid,
    input  wire  [1:0]        in_op,
    output logic              in_ready,
    input  rsfe_pkg::sts_t    sts,
    output rsfe_pkg::cmd_t    cmd
);

    typedef enum logic [13:0] {
        S_CLEAR   = 14'b00000000000001,
        S_IDLE    = 14'b00000000000010,
        S_CHECK   = 14'b00000000000100,
        S_MOD     = 14'b00000000001000,
        S_RD_TAB  = 14'b00000000010000,
        S_RD_HI   = 14'b00000000100000,
        S_RD_LO   = 14'b00000001000000,
        S_WR_A    = 14'b00000010000000,
        S_WR_B    = 14'b00000100000000,
        S_WR_C    = 14'b00001000000000,
        S_SEAL    = 14'b00010000000000,
        S_TX_RD   = 14'b00100000000000,
        S_TX_FORM = 14'b01000000000000,
        S_EMIT    = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (in_op)
                        rsfe_pkg::OP_RX_BYTE:   cmd.rx_store = 1'b1;
                        rsfe_pkg::OP_FRAME_END: state_next = S_CHECK;
                        rsfe_pkg::OP_TX_DONE:
                        begin
                            cmd.tx_adv = 1'b1;
                            if (sts.tx_has)
                            begin
                                state_next = S_TX_RD;
                            end
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_CHECK:
            begin
                cmd.check  = 1'b1;
                state_next = sts.chk_rej ? S_EMIT : S_MOD;
            end
            S_MOD:
            begin
                cmd.mod_step = 1'b1;
                if (sts.mod_last)
                begin
                    if (sts.cnt_zero)
                    begin
                        state_next = S_SEAL;
                    end
                    else
                    begin
                        state_next = sts.is_read ? S_RD_TAB : S_WR_A;
                    end
                end
            end
            S_RD_TAB:
            begin
                cmd.rd_tab = 1'b1;
                state_next = S_RD_HI;
            end
            S_RD_HI:
            begin
                cmd.rd_hi  = 1'b1;
                state_next = S_RD_LO;
            end
            S_RD_LO:
            begin
                cmd.rd_lo  = 1'b1;
                state_next = sts.loop_last ? S_SEAL : S_RD_TAB;
            end
            S_WR_A:
            begin
                cmd.wr_a   = 1'b1;
                state_next = S_WR_B;
            end
            S_WR_B:
            begin
                cmd.wr_b   = 1'b1;
                state_next = S_WR_C;
            end
            S_WR_C:
            begin
                cmd.wr_c   = 1'b1;
                state_next = sts.loop_last ? S_SEAL : S_WR_A;
            end
            S_SEAL:
            begin
                cmd.seal   = 1'b1;
                state_next = S_EMIT;
            end
            S_TX_RD:
            begin
                cmd.tx_rd  = 1'b1;
                state_next = S_TX_FORM;
            end
            S_TX_FORM:
            begin
                cmd.tx_form = 1'b1;
                state_next  = S_EMIT;
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_CLEAR;
        endcase
    end

endmodule
`default_nettype wire

/* src/rsfe_datapath.sv */
`default_nettype none
module rsfe_datapath #(
    parameter int RX_DEPTH  = 256,
    parameter int REG_COUNT = 256,
    parameter int MAX_REGS  = 64
) (
    input  wire               clk,
    input  wire               rst_n,
    input  wire  [7:0]        rx_byte,
    input  rsfe_pkg::cmd_t    cmd,
    output rsfe_pkg::sts_t    sts,
    output logic              out_valid,
    input  wire               out_ready,
    output logic [1:0]        out_status,
    output logic [7:0]        out_byte,
    output logic              out_last
);

    localparam int RX_AW = $clog2(RX_DEPTH);
    localparam int RX_CW = $clog2(RX_DEPTH + 1);
    localparam int IW    = $clog2(REG_COUNT);
    localparam int CW    = rsfe_pkg::CNT_W;

    // floor(2^32 / REG_COUNT) + 1 gives an exact quotient for any 16-bit start
    localparam logic [31:0] MOD_RECIP =
        32'((64'h1_0000_0000 / 64'(REG_COUNT)) + 64'd1);

    logic [7:0]  rx_mem [0:RX_DEPTH-1];
    logic [15:0] tab_mem [0:REG_COUNT-1];
    logic [7:0]  resp_mem [0:rsfe_pkg::RESP_DEPTH-1];

    logic [RX_CW-1:0] rcount_reg;
    logic             rx_par_reg;
    logic [7:0]       last1_reg, last2_reg;
    logic [7:0]       rx_hdr_reg [0:5];

    logic [7:0]       resp_hdr_reg [0:5];
    logic             resp_read_reg;
    logic             resp_par_reg;
    logic             trailer_reg;
    logic [8:0]       send_len_reg, send_pos_reg;

    logic [15:0]      start_sh_reg;
    logic [15:0]      quo_reg;
    logic             mod_cnt_reg;
    logic [IW-1:0]    idx_reg;
    logic [IW-1:0]    clr_cnt_reg;
    logic [CW-1:0]    cnt_reg, loop_i_reg;

    logic [7:0]       rx_rdata_reg, hi_reg, resp_rdata_reg;
    logic [15:0]      tab_rdata_reg;

    logic [1:0]       res_status_reg;
    logic [7:0]       res_byte_reg;
    logic             res_last_reg;

    logic             out_valid_reg;
    logic [1:0]       out_status_reg;
    logic [7:0]       out_byte_reg;
    logic             out_last_reg;

    // frame check
    logic        body_odd, trail_ok, n_short, too_many, write_short, chk_rej;
    logic [1:0]  chk_code;
    logic [15:0] count16;
    logic [17:0] write_need;
    logic [7:0]  cnt2;

    always_comb
    begin
        body_odd    = rx_par_reg ^ (^last1_reg) ^ (^last2_reg);
        trail_ok    = (last2_reg == 8'h00) && (last1_reg == {7'd0, ~body_odd});
        count16     = {rx_hdr_reg[4], rx_hdr_reg[5]};
        n_short     = rcount_reg < RX_CW'(rsfe_pkg::MIN_FRAME);
        too_many    = count16 > 16'(MAX_REGS);
        write_need  = {1'b0, count16, 1'b0} + 18'd9;
        write_short = 18'(rcount_reg) < write_need;
        cnt2        = {rx_hdr_reg[5][6:0], 1'b0};
        chk_rej     = 1'b1;
        chk_code    = rsfe_pkg::ST_CHECK;
        if (n_short || !trail_ok)
        begin
            chk_code = rsfe_pkg::ST_CHECK;
        end
        else if (rx_hdr_reg[1] == rsfe_pkg::FN_READ)
        begin
            chk_code = rsfe_pkg::ST_COUNT;
            chk_rej  = too_many;
        end
        else if (rx_hdr_reg[1] == rsfe_pkg::FN_WRITE)
        begin
            chk_code = too_many ? rsfe_pkg::ST_COUNT : rsfe_pkg::ST_CHECK;
            chk_rej  = too_many || write_short;
        end
        else
        begin
            chk_code = rsfe_pkg::ST_FUNCTION;
        end
    end

    // start modulo table size: quotient by reciprocal multiply, then remainder
    logic [47:0] mod_prod;
    logic [15:0] mod_back;
    logic [15:0] mod_rem;
    always_comb
    begin
        mod_prod = 48'(start_sh_reg) * 48'(MOD_RECIP);
        mod_back = quo_reg * 16'(REG_COUNT);
        mod_rem  = start_sh_reg - mod_back;
    end

    logic [IW-1:0] idx_inc;
    assign idx_inc = (idx_reg == IW'(REG_COUNT - 1)) ? '0 : idx_reg + 1'b1;

    logic [8:0] pos_adv;
    assign pos_adv = (send_pos_reg < send_len_reg) ? send_pos_reg + 9'd1 : send_pos_reg;

    logic [8:0] rx_off;
    assign rx_off = {1'b0, loop_i_reg, 1'b0} + (cmd.wr_a ? 9'd7 : 9'd8);

    logic [rsfe_pkg::RESP_AW-1:0] resp_waddr;
    assign resp_waddr = {loop_i_reg, 1'b0} + (cmd.rd_hi ? 8'd3 : 8'd4);

    // response byte at the current send position
    logic [7:0] tx_sel;
    always_comb
    begin
        if (send_pos_reg == send_len_reg - 9'd2)
        begin
            tx_sel = 8'h00;
        end
        else if (send_pos_reg == send_len_reg - 9'd1)
        begin
            tx_sel = {7'd0, trailer_reg};
        end
        else if (resp_read_reg && send_pos_reg >= 9'd3)
        begin
            tx_sel = resp_rdata_reg;
        end
        else
        begin
            tx_sel = resp_hdr_reg[send_pos_reg[2:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rx_store && rcount_reg < RX_CW'(RX_DEPTH))
        begin
            rx_mem[rcount_reg[RX_AW-1:0]] <= rx_byte;
        end
        if (cmd.wr_a || cmd.wr_b)
        begin
            rx_rdata_reg <= rx_mem[RX_AW'(rx_off)];
        end
        if (cmd.clr)
        begin
            tab_mem[clr_cnt_reg] <= 16'h0000;
        end
        else if (cmd.wr_c)
        begin
            tab_mem[idx_reg] <= {hi_reg, rx_rdata_reg};
        end
        if (cmd.rd_tab)
        begin
            tab_rdata_reg <= tab_mem[idx_reg];
        end
        if (cmd.rd_hi)
        begin
            resp_mem[resp_waddr] <= tab_rdata_reg[15:8];
        end
        else if (cmd.rd_lo)
        begin
            resp_mem[resp_waddr] <= tab_rdata_reg[7:0];
        end
        if (cmd.tx_rd)
        begin
            resp_rdata_reg <= resp_mem[send_pos_reg[rsfe_pkg::RESP_AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rx_store && rcount_reg < RX_CW'(RX_DEPTH))
        begin
            last1_reg <= rx_byte;
            last2_reg <= last1_reg;
            if (rcount_reg < RX_CW'(6))
            begin
                rx_hdr_reg[rcount_reg[2:0]] <= rx_byte;
            end
        end
        if (cmd.check)
        begin
            for (int k = 0; k < 6; k++)
            begin
                resp_hdr_reg[k] <= rx_hdr_reg[k];
            end
            if (rx_hdr_reg[1] == rsfe_pkg::FN_READ)
            begin
                resp_hdr_reg[2] <= cnt2;
            end
            resp_read_reg <= (rx_hdr_reg[1] == rsfe_pkg::FN_READ);
            resp_par_reg  <= (rx_hdr_reg[1] == rsfe_pkg::FN_READ)
                ? (^rx_hdr_reg[0]) ^ (^rx_hdr_reg[1]) ^ (^cnt2)
                : (^rx_hdr_reg[0]) ^ (^rx_hdr_reg[1]) ^ (^rx_hdr_reg[2])
                  ^ (^rx_hdr_reg[3]) ^ (^rx_hdr_reg[4]) ^ (^rx_hdr_reg[5]);
            start_sh_reg  <= {rx_hdr_reg[2], rx_hdr_reg[3]};
            cnt_reg       <= count16[CW-1:0];
            mod_cnt_reg   <= 1'b0;
            loop_i_reg    <= '0;
            res_status_reg <= chk_code;
            res_byte_reg   <= 8'h00;
            res_last_reg   <= 1'b0;
        end
        if (cmd.mod_step)
        begin
            mod_cnt_reg <= 1'b1;
            if (mod_cnt_reg)
            begin
                idx_reg <= mod_rem[IW-1:0];
            end
            else
            begin
                quo_reg <= mod_prod[47:32];
            end
        end
        if (cmd.rd_hi)
        begin
            resp_par_reg <= resp_par_reg ^ (^tab_rdata_reg[15:8]);
        end
        if (cmd.rd_lo)
        begin
            resp_par_reg <= resp_par_reg ^ (^tab_rdata_reg[7:0]);
        end
        if (cmd.wr_b)
        begin
            hi_reg <= rx_rdata_reg;
        end
        if (cmd.rd_lo || cmd.wr_c)
        begin
            loop_i_reg <= loop_i_reg + 1'b1;
            idx_reg    <= idx_inc;
        end
        if (cmd.seal)
        begin
            trailer_reg    <= ~resp_par_reg;
            res_status_reg <= rsfe_pkg::ST_OK;
            res_byte_reg   <= resp_hdr_reg[0];
            res_last_reg   <= 1'b0;
        end
        if (cmd.tx_form)
        begin
            res_status_reg <= rsfe_pkg::ST_OK;
            res_byte_reg   <= tx_sel;
            res_last_reg   <= (send_pos_reg + 9'd1 == send_len_reg);
        end
        if (cmd.emit)
        begin
            out_status_reg <= res_status_reg;
            out_byte_reg   <= res_byte_reg;
            out_last_reg   <= res_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rcount_reg    <= '0;
            rx_par_reg    <= 1'b0;
            send_len_reg  <= '0;
            send_pos_reg  <= '0;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cmd.rx_store && rcount_reg < RX_CW'(RX_DEPTH))
            begin
                rcount_reg <= rcount_reg + 1'b1;
                rx_par_reg <= rx_par_reg ^ (^rx_byte);
            end
            if (cmd.check)
            begin
                rcount_reg <= '0;
                rx_par_reg <= 1'b0;
                if (chk_rej)
                begin
                    send_len_reg <= '0;
                    send_pos_reg <= '0;
                end
            end
            if (cmd.seal)
            begin
                send_len_reg <= resp_read_reg ? {1'b0, cnt_reg, 1'b0} + 9'd5
                                              : 9'(rsfe_pkg::WRITE_LEN);
                send_pos_reg <= '0;
            end
            if (cmd.tx_adv)
            begin
                send_pos_reg <= pos_adv;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        sts.clr_last  = (clr_cnt_reg == IW'(REG_COUNT - 1));
        sts.chk_rej   = chk_rej;
        sts.is_read   = resp_read_reg;
        sts.cnt_zero  = (cnt_reg == '0);
        sts.mod_last  = mod_cnt_reg;
        sts.loop_last = (loop_i_reg + 1'b1 == cnt_reg);
        sts.tx_has    = pos_adv < send_len_reg;
        sts.out_free  = !out_valid_reg || out_ready;
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_byte   = out_byte_reg;
    assign out_last   = out_last_reg;

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        send_pos_reg <= send_len_reg)
        else $error("send position past response length");

    a_reject_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg != rsfe_pkg::ST_OK) |-> !out_last_reg)
        else $error("rejection marked as final byte");

    a_rx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rcount_reg <= RX_CW'(RX_DEPTH))
        else $error("receive count past depth");

    a_loop_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.rd_lo || cmd.wr_c) |-> loop_i_reg < cnt_reg)
        else $error("register loop overran count");

endmodule
`default_nettype wire

/* src/register_slave_frame_engine.sv */
`default_nettype none
// Register slave frame engine. Each input transaction carries an event in s_tuser
// (received byte, frame end, transmit complete) and a byte in s_tdata; results carry
// a status in m_tuser, a response byte in m_tdata and the final-byte mark in m_tlast.
// A received byte, an unused event or a transmit complete with nothing left to send
// is taken in the idle state. Otherwise a transmit complete reads the response
// memory, selects the byte and outputs it; a rejected frame end is checked and
// output; an accepted frame end is checked, its start index is reduced modulo
// REG_COUNT by a reciprocal multiply (quotient, then remainder), the register table
// port then moves one register per pass through its read or write states, and the
// response is sealed and output. After reset the engine clears the register table,
// one entry a cycle, before it accepts a transaction. A result waits in the output
// register until taken; the engine keeps accepting transactions meanwhile, and a
// further result waits inside the engine, which then accepts nothing until the
// output register is free.
module register_slave_frame_engine #(
    parameter int RX_DEPTH  = 256,
    parameter int REG_COUNT = 256,
    parameter int MAX_REGS  = 64
) (
    input  wire        clk,
    input  wire        rst_n,
    input  wire        s_tvalid,
    output logic       s_tready,
    input  wire  [7:0] s_tdata,   // [7:0] rx_byte
    input  wire  [1:0] s_tuser,   // [1:0] op
    output logic       m_tvalid,
    input  wire        m_tready,
    output logic [7:0] m_tdata,   // [7:0] tx_byte
    output logic [1:0] m_tuser,   // [1:0] status
    output logic       m_tlast
);

    rsfe_pkg::cmd_t cmd;
    rsfe_pkg::sts_t sts;

    rsfe_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_op    (s_tuser),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    rsfe_datapath #(
        .RX_DEPTH  (RX_DEPTH),
        .REG_COUNT (REG_COUNT),
        .MAX_REGS  (MAX_REGS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx_byte    (s_tdata),
        .cmd        (cmd),
        .sts        (sts),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_status (m_tuser),
        .out_byte   (m_tdata),
        .out_last   (m_tlast)
    );

endmodule
`default_nettype wire

/* bench/register_slave_frame_engine_tb.sv */
`default_nettype none
module register_slave_frame_engine_tb;

    localparam int RXD = 256;
    localparam int REGN = 256;
    localparam int MAXR = 64;
    localparam int WATCHDOG = 200000;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] tx_byte;
        logic       last;
    } resp_t;

    logic       clk;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic [1:0] s_tuser;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic [1:0] m_tuser;
    logic       m_tlast;

    register_slave_frame_engine i_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    // predictor state
    logic [7:0]  rx_buf [RXD];
    int          rx_len;
    logic [15:0] reg_tab [REGN];
    logic [7:0]  resp_buf [256];
    int          tx_pos;
    int          tx_len;

    resp_t expected_q[$];
    int    mismatches = 0;
    int    idle_cycles = 0;
    int    send_idle_pct;
    int    recv_idle_pct;
    bit    hold_req;
    bit    hold_busy;
    bit    hold_done;

    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic byte_parity_odd(input logic [7:0] b);
        return ^b;
    endfunction

    function automatic void reject_frame(input logic [1:0] code);
        resp_t r;
        tx_len = 0;
        tx_pos = 0;
        r.status = code;
        r.tx_byte = 8'h00;
        r.last = 1'b0;
        expected_q.push_back(r);
    endfunction

    function automatic void seal(input int len);
        logic odd;
        resp_t r;
        odd = 1'b0;
        for (int i = 0; i < len - 2; i++)
            odd ^= byte_parity_odd(resp_buf[i]);
        resp_buf[len - 2] = 8'h00;
        resp_buf[len - 1] = odd ? 8'h00 : 8'h01;
        tx_len = len;
        tx_pos = 0;
        r.status = rsfe_pkg::ST_OK;
        r.tx_byte = resp_buf[0];
        r.last = 1'b0;
        expected_q.push_back(r);
    endfunction

    function automatic void predict_frame_end();
        int n;
        int first;
        int cnt;
        logic odd;
        n = rx_len;
        rx_len = 0;
        if (n < rsfe_pkg::MIN_FRAME)
        begin
            reject_frame(rsfe_pkg::ST_CHECK);
            return;
        end
        odd = 1'b0;
        for (int i = 0; i < n - 2; i++)
            odd ^= byte_parity_odd(rx_buf[i]);
        if (rx_buf[n - 2] != 8'h00 || rx_buf[n - 1] != (odd ? 8'h00 : 8'h01))
        begin
            reject_frame(rsfe_pkg::ST_CHECK);
            return;
        end
        first = int'({rx_buf[2], rx_buf[3]});
        cnt = int'({rx_buf[4], rx_buf[5]});
        if (rx_buf[1] == rsfe_pkg::FN_READ)
        begin
            if (cnt > MAXR)
            begin
                reject_frame(rsfe_pkg::ST_COUNT);
                return;
            end
            resp_buf[0] = rx_buf[0];
            resp_buf[1] = rx_buf[1];
            resp_buf[2] = 8'(cnt * 2);
            for (int i = 0; i < cnt; i++)
            begin
                resp_buf[3 + 2 * i] = reg_tab[(first + i) % REGN][15:8];
                resp_buf[4 + 2 * i] = reg_tab[(first + i) % REGN][7:0];
            end
            seal(5 + 2 * cnt);
        end
        else if (rx_buf[1] == rsfe_pkg::FN_WRITE)
        begin
            if (cnt > MAXR)
            begin
                reject_frame(rsfe_pkg::ST_COUNT);
                return;
            end
            if (n < 9 + 2 * cnt)
            begin
                reject_frame(rsfe_pkg::ST_CHECK);
                return;
            end
            for (int i = 0; i < 6; i++)
                resp_buf[i] = rx_buf[i];
            for (int i = 0; i < cnt; i++)
                reg_tab[(first + i) % REGN] = {rx_buf[7 + 2 * i], rx_buf[8 + 2 * i]};
            seal(rsfe_pkg::WRITE_LEN);
        end
        else
            reject_frame(rsfe_pkg::ST_FUNCTION);
    endfunction

    function automatic void predict_event(input logic [1:0] op, input logic [7:0] b);
        resp_t r;
        if (op == rsfe_pkg::OP_RX_BYTE)
        begin
            if (rx_len < RXD)
            begin
                rx_buf[rx_len] = b;
                rx_len++;
            end
        end
        else if (op == rsfe_pkg::OP_FRAME_END)
            predict_frame_end();
        else if (op == rsfe_pkg::OP_TX_DONE)
        begin
            if (tx_pos < tx_len)
                tx_pos++;
            if (tx_pos < tx_len)
            begin
                r.status = rsfe_pkg::ST_OK;
                r.tx_byte = resp_buf[tx_pos];
                r.last = (tx_pos + 1 == tx_len);
                expected_q.push_back(r);
            end
        end
    endfunction

    // tvalid stays high after an accept; the next call may drop it, wait_idle drops it
    task automatic send_event(input logic [1:0] op, input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= b;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_event(op, b);
    endtask

    task automatic send_rx(input logic [7:0] b);
        send_event(rsfe_pkg::OP_RX_BYTE, b);
    endtask

    // send body bytes followed by a trailer, good or corrupted
    task automatic send_frame(input logic [7:0] body[$], input bit bad_trailer);
        logic odd;
        odd = 1'b0;
        foreach (body[i])
        begin
            odd ^= ^body[i];
            send_rx(body[i]);
        end
        send_rx(8'h00);
        send_rx((odd ? 8'h00 : 8'h01) ^ {7'd0, bad_trailer});
        send_event(rsfe_pkg::OP_FRAME_END, 8'h00);
    endtask

    task automatic drain_response();
        int k;
        k = 0;
        while (tx_pos + 1 < tx_len && k < 200)
        begin
            send_event(rsfe_pkg::OP_TX_DONE, 8'($urandom));
            k++;
        end
    endtask

    task automatic build_request(output logic [7:0] body[$], input logic [7:0] fn,
                                 input logic [15:0] first, input logic [15:0] cnt,
                                 input int data_words);
        body = {};
        body.push_back(8'($urandom));
        body.push_back(fn);
        body.push_back(first[15:8]);
        body.push_back(first[7:0]);
        body.push_back(cnt[15:8]);
        body.push_back(cnt[7:0]);
        if (fn == rsfe_pkg::FN_WRITE)
        begin
            body.push_back(8'(cnt * 2));
            for (int i = 0; i < 2 * data_words; i++)
                body.push_back(8'($urandom));
        end
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic test_directed();
        logic [7:0] body[$];
        send_event(rsfe_pkg::OP_TX_DONE, 8'h00);     // idle transmit complete
        send_event(rsfe_pkg::OP_UNUSED, 8'hFF);      // unused op
        send_event(rsfe_pkg::OP_FRAME_END, 8'h00);   // empty frame
        for (int i = 0; i < 5; i++)
            send_rx(8'($urandom));
        send_event(rsfe_pkg::OP_FRAME_END, 8'h00);   // short frame
        build_request(body, rsfe_pkg::FN_WRITE, 16'hFFFF, 16'd3, 3);
        send_frame(body, 1'b0);
        drain_response();
        build_request(body, rsfe_pkg::FN_READ, 16'hFFFF, 16'd3, 0);
        send_frame(body, 1'b0);
        drain_response();
        send_event(rsfe_pkg::OP_TX_DONE, 8'h00);
        build_request(body, rsfe_pkg::FN_READ, 16'h0000, 16'd0, 0);
        send_frame(body, 1'b0);
        drain_response();
        build_request(body, rsfe_pkg::FN_READ, 16'h00FF, 16'd64, 0);
        send_frame(body, 1'b0);
        send_event(rsfe_pkg::OP_TX_DONE, 8'h00);
        build_request(body, rsfe_pkg::FN_READ, 16'h0000, 16'd65, 0);
        send_frame(body, 1'b0);              // count too large, drops response
        send_event(rsfe_pkg::OP_TX_DONE, 8'h00);
        build_request(body, rsfe_pkg::FN_WRITE, 16'h8000, 16'hFFFF, 0);
        send_frame(body, 1'b0);
        build_request(body, rsfe_pkg::FN_WRITE, 16'h0010, 16'd4, 2);
        send_frame(body, 1'b0);              // short write frame
        build_request(body, rsfe_pkg::FN_READ, 16'h0001, 16'd2, 0);
        send_frame(body, 1'b1);              // bad trailer
        build_request(body, 8'h7F, 16'h0001, 16'd2, 0);
        send_frame(body, 1'b0);              // unknown function
        for (int i = 0; i < 258; i++)
            send_rx(8'hA5);                  // overflow
        send_event(rsfe_pkg::OP_FRAME_END, 8'h00);
        wait_idle();
    endtask

    task automatic test_random(input int n_items);
        logic [7:0] body[$];
        int sent;
        int sel;
        int cnt;
        int words;
        logic [7:0] fn;
        sent = 0;
        while (sent < n_items)
        begin
            sel = $urandom_range(99);
            cnt = ($urandom_range(9) == 0) ? $urandom_range(MAXR) : $urandom_range(6);
            fn = ($urandom_range(1) != 0) ? rsfe_pkg::FN_READ : rsfe_pkg::FN_WRITE;
            if (sel < 5)
                fn = 8'($urandom);
            if (sel >= 5 && sel < 8)
                cnt = $urandom_range(65535);
            if (cnt > MAXR)
                words = 0;
            else if (sel >= 8 && sel < 11)
                words = $urandom_range(cnt);
            else
                words = cnt;
            build_request(body, fn, 16'($urandom), 16'(cnt), words);
            send_frame(body, sel >= 11 && sel < 15);
            sent += body.size() + 3;
            if (sel < 80)
            begin
                if ($urandom_range(3) == 0 && tx_len > 2)
                    repeat ($urandom_range(tx_len - 1))
                        send_event(rsfe_pkg::OP_TX_DONE, 8'h00);
                else
                    drain_response();
                sent += tx_len;
            end
            else if (sel < 90)
            begin
                repeat ($urandom_range(20))
                begin
                    send_event(2'($urandom), 8'($urandom));
                    sent++;
                end
            end
        end
    endtask

    task automatic test_backpressure();
        logic [7:0] body[$];
        hold_req = 1'b1;
        build_request(body, rsfe_pkg::FN_READ, 16'h0000, 16'd20, 0);
        send_frame(body, 1'b0);
        drain_response();
        wait_idle();
    endtask

    // checker
    always @(posedge clk)
    begin
        resp_t got;
        resp_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = '{status: m_tuser, tx_byte: m_tdata, last: m_tlast};
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected none, actual %p", got);
            end
            else
            begin
                want = expected_q.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p, actual %p", want, got);
                end
            end
        end
    end

    // receiver: random stalls, plus one long hold when requested
    always @(posedge clk)
    begin
        if (hold_req && !hold_done)
        begin
            hold_busy <= 1'b1;
            m_tready <= 1'b0;
            repeat (3000) @(posedge clk);
            hold_done <= 1'b1;
            hold_busy <= 1'b0;
        end
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n || hold_busy)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("FAIL register_slave_frame_engine");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = 8'h00;
        s_tuser = rsfe_pkg::OP_RX_BYTE;
        hold_req = 1'b0;
        rx_len = 0;
        tx_pos = 0;
        tx_len = 0;
        foreach (reg_tab[i])
            reg_tab[i] = 16'h0000;
        send_idle_pct = 25;
        recv_idle_pct = 57;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(60);
        test_backpressure();
        send_idle_pct = 57;
        recv_idle_pct = 25;
        test_random(60);
        wait_idle();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(60);
        wait_idle();
        if (mismatches == 0 && expected_q.size() == 0)
            $display("PASS register_slave_frame_engine");
        else
            $display("FAIL register_slave_frame_engine");
        $finish;
    end
endmodule
`default_nettype wire
